// ===== rtl/rrq_pkg.sv =====
// shared types and codes for the round-robin entry queue
package rrq_pkg;

    // operation codes carried in the input tuser
    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_ADVANCE = 3'd2;
    localparam logic [2:0] OP_REMOVE  = 3'd3;
    localparam logic [2:0] OP_FIND    = 3'd4;

    // status codes carried in the output tuser
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam int ID_W      = 32;
    localparam int PLAYER_W  = 2;
    localparam int PAYLOAD_W = 16;

    // one stored queue entry
    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [PLAYER_W-1:0]  player;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    // what every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

endpackage

// ===== rtl/rrq_cell.sv =====
// one queue cell: holds an entry and takes data from its neighbor, the write port or the head
module rrq_cell
    import rrq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  cell_op_t         cell_op,
    input  logic [CNT_W-1:0] count,
    input  entry_t           wr_entry,
    input  entry_t           head_entry,
    input  entry_t           next_entry,
    output entry_t           entry
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   is_tail;
    logic   is_last;
    logic   is_inner;

    // position of this cell against the fill level
    assign is_tail  = (count == CNT_W'(IDX));
    assign is_last  = (count == CNT_W'(IDX + 1));
    assign is_inner = (count > CNT_W'(IDX + 1));

    // select the next content of the cell
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cell_op)
            CELL_WRITE:
            begin
                if (is_tail)
                begin
                    entry_next = wr_entry;
                end
            end
            CELL_SHIFT:
            begin
                if (is_inner)
                begin
                    entry_next = next_entry;
                end
            end
            CELL_ROTATE:
            begin
                if (is_inner)
                begin
                    entry_next = next_entry;
                end
                else if (is_last)
                begin
                    entry_next = head_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/round_robin_entry_queue.sv =====
// top level of the round-robin entry queue
// The queue is a row of CAPACITY cells, cell 0 holding the head; one transaction
// is taken at a time. Push, pop, advance and unknown opcodes are carried out on
// acceptance. A remove rotates until the match reaches the head and then pops
// it, and a failed remove or any find rotates through the whole count, because
// the cell chain rotates by one place per cycle while the head cell is compared
// with the key. A find rotates the full count so the order is left as it was.
// The next transaction is accepted once the result has been loaded into the
// output register.
module round_robin_entry_queue
    import rrq_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int OUT_W    = ((2 * ID_W + PLAYER_W + PAYLOAD_W + CNT_W + 1 + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [2:0]       s_tuser,   // op
    input  logic [55:0]      s_tdata,   // player, payload, key_id, zero fill
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [1:0]       m_tuser,   // status
    output logic [OUT_W-1:0] m_tdata    // out_id, out_player, out_payload, count,
                                        // head_valid, head_id, zero fill
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_REPORT
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ID_W-1:0]      id_ctr_reg, id_ctr_next;
    logic [IDX_W-1:0]     step_reg, step_next;
    logic                 found_reg, found_next;
    logic                 is_find_reg, is_find_next;
    logic [ID_W-1:0]      key_reg, key_next;
    logic [1:0]           res_status_reg, res_status_next;
    entry_t               res_entry_reg, res_entry_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    cell_op_t             cell_op;
    entry_t               wr_entry;
    entry_t               cells [CAPACITY];
    entry_t               head;
    logic                 key_match;
    logic                 out_free;
    logic [ID_W-1:0]      id_inc;
    logic [2:0]           in_op;
    entry_t               in_entry;
    logic [ID_W-1:0]      in_key;
    logic                 head_valid;
    logic [ID_W-1:0]      head_id;

    // unpack the input transaction
    assign in_op            = s_tuser;
    assign in_entry.player  = s_tdata[1:0];
    assign in_entry.payload = s_tdata[17:2];
    assign in_entry.id      = id_inc;
    assign in_key           = s_tdata[49:18];

    assign head      = cells[0];
    assign key_match = (head.id == key_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign id_inc    = (id_ctr_reg == '1) ? ID_W'(1) : id_ctr_reg + ID_W'(1);
    assign wr_entry  = in_entry;

    // chain of cells, cell 0 is the head
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t nxt;
        if (i == CAPACITY - 1)
        begin : g_end
            assign nxt = '0;
        end
        else
        begin : g_mid
            assign nxt = cells[i + 1];
        end

        rrq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .cell_op    (cell_op),
            .count      (count_reg),
            .wr_entry   (wr_entry),
            .head_entry (head),
            .next_entry (nxt),
            .entry      (cells[i])
        );
    end

    // head as seen after the operation
    assign head_valid = (count_reg != '0);
    assign head_id    = head_valid ? head.id : '0;

    // control and result sequencing
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        id_ctr_next     = id_ctr_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        is_find_next    = is_find_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        cell_op         = CELL_HOLD;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_status_next = ST_OK;
                    res_entry_next  = '0;
                    state_next      = S_REPORT;
                    if (in_op == OP_PUSH)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            cell_op        = CELL_WRITE;
                            count_next     = count_reg + CNT_W'(1);
                            id_ctr_next    = id_inc;
                            res_entry_next = in_entry;
                        end
                    end
                    else if (in_op == OP_POP || in_op == OP_ADVANCE ||
                             in_op == OP_REMOVE || in_op == OP_FIND)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else if (in_op == OP_POP)
                        begin
                            cell_op        = CELL_SHIFT;
                            count_next     = count_reg - CNT_W'(1);
                            res_entry_next = head;
                        end
                        else if (in_op == OP_ADVANCE)
                        begin
                            cell_op = CELL_ROTATE;
                        end
                        else
                        begin
                            key_next     = in_key;
                            is_find_next = (in_op == OP_FIND);
                            step_next    = '0;
                            found_next   = 1'b0;
                            state_next   = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (!is_find_reg && key_match)
                begin
                    // match at the head: pop it
                    cell_op         = CELL_SHIFT;
                    count_next      = count_reg - CNT_W'(1);
                    res_entry_next  = head;
                    res_status_next = ST_OK;
                    state_next      = S_REPORT;
                end
                else
                begin
                    cell_op   = CELL_ROTATE;
                    step_next = step_reg + IDX_W'(1);
                    if (is_find_reg && key_match && !found_reg)
                    begin
                        found_next     = 1'b1;
                        res_entry_next = head;
                    end
                    if (CNT_W'(step_reg) == count_reg - CNT_W'(1))
                    begin
                        state_next = S_REPORT;
                        if (found_reg || (is_find_reg && key_match))
                        begin
                            res_status_next = ST_OK;
                        end
                        else
                        begin
                            res_status_next = ST_MISSING;
                            res_entry_next  = '0;
                        end
                    end
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = OUT_W'({head_id, head_valid,
                                            count_reg, res_entry_reg.payload,
                                            res_entry_reg.player, res_entry_reg.id});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            id_ctr_reg     <= '0;
            step_reg       <= '0;
            found_reg      <= 1'b0;
            is_find_reg    <= 1'b0;
            key_reg        <= '0;
            res_status_reg <= ST_OK;
            res_entry_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tuser_reg    <= ST_OK;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            id_ctr_reg     <= id_ctr_next;
            step_reg       <= step_next;
            found_reg      <= found_next;
            is_find_reg    <= is_find_next;
            key_reg        <= key_next;
            res_status_reg <= res_status_next;
            res_entry_reg  <= res_entry_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tuser_reg    <= m_tuser_next;
            m_tdata_reg    <= m_tdata_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== test/tb_top.sv =====
// testbench for the round-robin entry queue: directed and random operations checked by a predictor
module tb_top
    import rrq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 16;
    localparam int TIMEOUT_NS = 10_000_000;
    localparam int RANDOM_PER_PHASE = 450;

    // expected contents of one result transaction, m_tdata order from the top bit down
    typedef struct packed {
        logic [ID_W-1:0]      head_id;
        logic                 head_valid;
        logic [4:0]           count;
        logic [PAYLOAD_W-1:0] payload;
        logic [PLAYER_W-1:0]  player;
        logic [ID_W-1:0]      id;
    } result_bits_t;

    typedef struct {
        logic [1:0]   status;
        result_bits_t bits;
    } queue_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser = 3'd0;
    logic [55:0] s_tdata = 56'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [1:0]  m_tuser;
    logic [87:0] m_tdata;

    // predictor state: entries in order from the head
    entry_t          model_entries[$];
    logic [ID_W-1:0] model_last_id = '0;
    queue_result_t   pending_results[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_left = 0;
    int mismatch_count = 0;

    round_robin_entry_queue #(.CAPACITY(CAPACITY)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // position of the first entry carrying the key, or the queue size when absent
    function automatic int find_position(logic [ID_W-1:0] key);
        for (int k = 0; k < model_entries.size(); k++)
        begin
            if (model_entries[k].id == key)
                return k;
        end
        return model_entries.size();
    endfunction

    // apply one operation to the predicted queue and return the expected result
    function automatic queue_result_t apply_queue_op(logic [2:0] op, logic [1:0] player,
                                                     logic [15:0] payload, logic [31:0] key);
        queue_result_t r;
        entry_t        e;
        int            k;
        r.status = ST_OK;
        r.bits = '0;
        if (op == OP_PUSH)
        begin
            if (model_entries.size() >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                model_last_id = (model_last_id == '1) ? 32'd1 : model_last_id + 32'd1;
                e.id = model_last_id;
                e.player = player;
                e.payload = payload;
                model_entries.push_back(e);
                r.bits.id = e.id;
                r.bits.player = e.player;
                r.bits.payload = e.payload;
            end
        end
        else if (op == OP_POP || op == OP_ADVANCE || op == OP_REMOVE || op == OP_FIND)
        begin
            if (model_entries.size() == 0)
                r.status = ST_EMPTY;
            else if (op == OP_POP)
            begin
                e = model_entries.pop_front();
                r.bits.id = e.id;
                r.bits.player = e.player;
                r.bits.payload = e.payload;
            end
            else if (op == OP_ADVANCE)
                model_entries.push_back(model_entries.pop_front());
            else
            begin
                k = find_position(key);
                if (k >= model_entries.size())
                    r.status = ST_MISSING;
                else
                begin
                    e = model_entries[k];
                    r.bits.id = e.id;
                    r.bits.player = e.player;
                    r.bits.payload = e.payload;
                    // remove rotates the match to the head, so earlier entries move to the tail
                    if (op == OP_REMOVE)
                    begin
                        for (int i = 0; i < k; i++)
                            model_entries.push_back(model_entries.pop_front());
                        void'(model_entries.pop_front());
                    end
                end
            end
        end
        r.bits.count = 5'(model_entries.size());
        r.bits.head_valid = (model_entries.size() != 0);
        r.bits.head_id = (model_entries.size() != 0) ? model_entries[0].id : '0;
        return r;
    endfunction

    // drive one input transaction and record its expected result on acceptance
    task automatic send_item(logic [2:0] op, logic [1:0] player, logic [15:0] payload,
                             logic [31:0] key);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'd0, key, payload, player};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_queue_op(op, player, payload, key));
    endtask

    // stop offering and wait until every expected result has come back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // key that mostly hits a stored entry, otherwise a stale, future or random id
    function automatic logic [31:0] pick_key();
        if (model_entries.size() != 0 && $urandom_range(99) < 75)
            return model_entries[$urandom_range(model_entries.size() - 1)].id;
        case ($urandom_range(3))
            0: return $urandom();
            1: return model_last_id + 32'd1;
            2: return (model_last_id > 1) ? model_last_id - $urandom_range(1) : 32'd0;
            default: return ~32'd0;
        endcase
    endfunction

    // receiver: random stalls plus a counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // compare every result transaction with the oldest expectation
    always @(posedge clk)
    begin
        queue_result_t want;
        result_bits_t  got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d data %h", m_tuser, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status || got.id !== want.bits.id
                    || got.player !== want.bits.player || got.payload !== want.bits.payload
                    || got.count !== want.bits.count || got.head_valid !== want.bits.head_valid
                    || got.head_id !== want.bits.head_id)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected status %0d id %h player %0d payload %h",
                                 want.status, want.bits.id, want.bits.player, want.bits.payload);
                        $display("          count %0d head_valid %0d head_id %h",
                                 want.bits.count, want.bits.head_valid, want.bits.head_id);
                        $display("          actual status %0d id %h player %0d payload %h",
                                 m_tuser, got.id, got.player, got.payload);
                        $display("          count %0d head_valid %0d head_id %h",
                                 got.count, got.head_valid, got.head_id);
                    end
                end
            end
        end
    end

    // corner cases: empty queue, field extremes, full queue, hits and misses
    task automatic test_directed();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_item(OP_POP, 2'd0, 16'd0, 32'd0);
        send_item(OP_ADVANCE, 2'd0, 16'd0, 32'd0);
        send_item(OP_REMOVE, 2'd0, 16'd0, 32'd1);
        send_item(OP_FIND, 2'd0, 16'd0, 32'd1);
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i % 2 == 0)
                send_item(OP_PUSH, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
            else
                send_item(OP_PUSH, 2'd0, 16'h0000, 32'd0);
        end
        send_item(OP_PUSH, 2'd1, 16'h1234, 32'd0);
        send_item(OP_FIND, 2'd0, 16'd0, model_last_id);
        send_item(OP_REMOVE, 2'd0, 16'd0, model_entries[CAPACITY / 2].id);
        send_item(OP_REMOVE, 2'd0, 16'd0, 32'hFFFF_FFFF);
        send_item(OP_ADVANCE, 2'd0, 16'd0, 32'd0);
        send_item(OP_POP, 2'd0, 16'd0, 32'd0);
        send_item(3'd7, 2'd2, 16'hA5A5, 32'd0);
    endtask

    // random operations under each idling mix, alternating filling and draining stretches
    task automatic test_random();
        int idle_mix[4] = '{0, 60, 0, 21};
        int stall_mix[4] = '{0, 0, 60, 21};
        int pick;
        int push_weight;
        logic [2:0] op;
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_mix[p];
            receiver_stall_pct = stall_mix[p];
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                push_weight = ((i / 40) % 2 == 0) ? 50 : 15;
                pick = $urandom_range(99);
                if (pick < push_weight)
                    op = OP_PUSH;
                else if (pick < push_weight + 10)
                    op = OP_POP;
                else if (pick < push_weight + 22)
                    op = OP_ADVANCE;
                else if (pick < 95)
                    op = ($urandom_range(1) == 0) ? OP_REMOVE : OP_FIND;
                else
                    op = 3'($urandom_range(7, 5));
                send_item(op, 2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                          pick_key());
            end
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        @(posedge clk);
        hold_left = 300;
        for (int i = 0; i < 12; i++)
            send_item((i % 3 == 0) ? OP_FIND : OP_PUSH, 2'($urandom_range(3)),
                      16'($urandom_range(16'hFFFF)), pick_key());
    endtask

    // sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 10; i++)
            send_item(OP_PUSH, 2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)), 32'd0);
        wait_drained();
        for (int i = 0; i < 10; i++)
            send_item((i % 2 == 0) ? OP_REMOVE : OP_POP, 2'd0, 16'd0, pick_key());
    endtask

    // reset, run every test, then report
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        test_drain_pause();
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rrq_pkg.sv
rtl/rrq_cell.sv
rtl/round_robin_entry_queue.sv
test/tb_top.sv
